// File: rtl/pet_det_pkg.sv
package pet_det_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int AVG_W       = 16;
    localparam int EXT_W       = AVG_W + 2;
    localparam int LEVEL_W     = 12;
    localparam int PAD_W       = 8;
    localparam int HOLD_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NOISE_PADDING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 1'b1;

    localparam logic [AVG_W-1:0]  BIAS_RESET  = AVG_W'(511 << 4);
    localparam logic [AVG_W-1:0]  UPPER_RESET = AVG_W'(520 << 4);
    localparam logic [AVG_W-1:0]  LOWER_RESET = AVG_W'(500 << 4);
    localparam logic [PAD_W-1:0]  PAD_RESET   = PAD_W'(16);
    localparam logic [HOLD_W-1:0] HOLD_RESET  = HOLD_W'(200);

    // One step of the average: x + s - ((x - 8) >>> 4), wrapped to 16 bits.
    function automatic logic [AVG_W-1:0] ewma_update(
        input logic [AVG_W-1:0]       x,
        input logic [SAMPLE_BITS-1:0] s
    );
        logic signed [EXT_W-1:0] xm;
        logic signed [EXT_W-1:0] q;
        logic signed [EXT_W-1:0] r;
        xm = $signed({2'b00, x}) - $signed(EXT_W'(8));
        q  = xm >>> 4;
        r  = $signed({{(EXT_W-SAMPLE_BITS){1'b0}}, s}) + $signed({2'b00, x}) - q;
        return r[AVG_W-1:0];
    endfunction

endpackage

// File: rtl/piezo_envelope_trigger_detector.sv
// A sample request that is accepted is held in the input register; its result then goes
// to the result register. Throughput: one sample per cycle unless result_stall holds a
// result; the averages, band and timer settle in one pass of logic between the two registers.
// Reset (rst_n, asynchronous, active low) loads the averages with their start
// values, clears the hold timer and switch, and restores both registers' defaults.
module piezo_envelope_trigger_detector
    import pet_det_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_IDX_W-1:0]   wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic                   trigger_low,
    output logic                   trigger_high,
    output logic                   switch_on,
    output logic [LEVEL_W-1:0]     bias_level,
    output logic [LEVEL_W-1:0]     low_level,
    output logic [LEVEL_W-1:0]     high_level
);

    logic [PAD_W-1:0]       noise_padding_reg;
    logic [HOLD_W-1:0]      hold_ticks_reg;

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    logic [AVG_W-1:0]       bias_reg;
    logic [AVG_W-1:0]       upper_reg;
    logic [AVG_W-1:0]       lower_reg;
    logic [HOLD_W-1:0]      hold_timer_reg;
    logic                   switch_reg;

    logic                   out_valid_reg;
    logic                   tlow_reg;
    logic                   thigh_reg;
    logic                   sw_out_reg;
    logic [LEVEL_W-1:0]     bias_lvl_reg;
    logic [LEVEL_W-1:0]     low_lvl_reg;
    logic [LEVEL_W-1:0]     high_lvl_reg;

    logic                   out_free;
    logic                   move;
    logic                   take;

    logic [AVG_W-1:0]       bias_next;
    logic [AVG_W-1:0]       upper_next;
    logic [AVG_W-1:0]       lower_next;
    logic [HOLD_W-1:0]      hold_timer_next;
    logic                   switch_next;
    logic [AVG_W-1:0]       mid;
    logic [AVG_W-1:0]       noise;
    logic signed [EXT_W-1:0] lo_th;
    logic [EXT_W-1:0]       hi_th;
    logic [EXT_W-1:0]       s_ext;
    logic                   tlow;
    logic                   thigh;

    assign out_free     = !out_valid_reg || !result_stall;
    assign move         = in_valid_reg && out_free;
    assign take         = sample_valid && !sample_stall;
    assign sample_stall = in_valid_reg && !out_free;

    always_comb
    begin
        s_ext     = {{(EXT_W-SAMPLE_BITS){1'b0}}, in_sample_reg};
        bias_next = ewma_update(bias_reg, in_sample_reg);
        mid       = {4'b0000, bias_next[AVG_W-1:4]};
        upper_next = upper_reg;
        lower_next = lower_reg;
        if ({{(AVG_W-SAMPLE_BITS){1'b0}}, in_sample_reg} > mid)
        begin
            upper_next = ewma_update(upper_reg, in_sample_reg);
        end
        if ({{(AVG_W-SAMPLE_BITS){1'b0}}, in_sample_reg} < mid)
        begin
            lower_next = ewma_update(lower_reg, in_sample_reg);
        end
        noise = upper_next - lower_next + {{(AVG_W-PAD_W){1'b0}}, noise_padding_reg};

        // The low threshold may go negative; the floor shift keeps it below any sample.
        lo_th = ($signed({2'b00, bias_next}) - $signed({2'b00, noise})) >>> 4;
        hi_th = ({2'b00, bias_next} + {2'b00, noise}) >> 4;
        tlow  = $signed(s_ext) < lo_th;
        thigh = !tlow && (s_ext > hi_th);

        hold_timer_next = hold_timer_reg;
        switch_next     = switch_reg;
        if (tlow || thigh)
        begin
            hold_timer_next = hold_ticks_reg;
            switch_next     = 1'b1;
        end
        else if (hold_timer_reg != '0)
        begin
            hold_timer_next = hold_timer_reg - HOLD_W'(1);
        end
        else
        begin
            switch_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_padding_reg <= PAD_RESET;
            hold_ticks_reg    <= HOLD_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_NOISE_PADDING: noise_padding_reg <= wr_data[PAD_W-1:0];
                REG_HOLD_TICKS:    hold_ticks_reg    <= wr_data[HOLD_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            bias_reg       <= BIAS_RESET;
            upper_reg      <= UPPER_RESET;
            lower_reg      <= LOWER_RESET;
            hold_timer_reg <= '0;
            switch_reg     <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                in_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg  <= 1'b1;
                bias_reg       <= bias_next;
                upper_reg      <= upper_next;
                lower_reg      <= lower_next;
                hold_timer_reg <= hold_timer_next;
                switch_reg     <= switch_next;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_sample_reg <= sample;
        end
        if (move)
        begin
            tlow_reg     <= tlow;
            thigh_reg    <= thigh;
            sw_out_reg   <= switch_next;
            bias_lvl_reg <= bias_next[AVG_W-1:4];
            low_lvl_reg  <= lower_next[AVG_W-1:4];
            high_lvl_reg <= upper_next[AVG_W-1:4];
        end
    end

    assign result_valid = out_valid_reg;
    assign trigger_low  = tlow_reg;
    assign trigger_high = thigh_reg;
    assign switch_on    = sw_out_reg;
    assign bias_level   = bias_lvl_reg;
    assign low_level    = low_lvl_reg;
    assign high_level   = high_lvl_reg;

`ifndef SYNTHESIS
    a_one_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(tlow_reg && thigh_reg))
        else $error("both trigger indicators set");

    a_trigger_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (tlow_reg || thigh_reg)) |-> sw_out_reg)
        else $error("trigger without switch on");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (in_valid_reg && out_valid_reg && result_stall))
        else $error("input stalled without a blocked result");

    a_timer_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (move && (tlow || thigh)) |=> (hold_timer_reg == $past(hold_ticks_reg)))
        else $error("hold timer not reloaded on trigger");
`endif

endmodule
